### hw/rtl/bloom_filter_double_hash_top_macros.svh
// Assertion macros for the checker file bfdh_checker.sv.
`ifndef BLOOM_FILTER_DOUBLE_HASH_TOP_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFDH_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bloom filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFDH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bloom filter check failed");

`endif

### hw/rtl/bfdh_pkg.sv
`default_nettype none

package bfdh_pkg;

    localparam int DEF_MAX_FILTER_BITS = 65536;
    // Probe positions are kept modulo 2^PROBE_W, enough for the largest filter.
    localparam int PROBE_W       = 26;
    localparam int MIN_SIZE_LOG2 = 6;
    localparam int MAX_PROBES    = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int BIT_SEL_W     = 6;

    localparam int FP_W    = 64;
    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 10;
    localparam int COUNT_W = 5;
    localparam int LOG2_W  = 5;

    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int S_PAD_W   = S_TDATA_W - FP_W - WIDX_W - WORD_W;
    localparam int M_PAD_W   = M_TDATA_W - WORD_W - 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SEED  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_LOG2  = 2'd2;

    localparam logic [COUNT_W-1:0] HASH_COUNT_RESET = 5'd7;
    localparam logic [LOG2_W-1:0]  SIZE_LOG2_RESET  = 5'd16;

    localparam logic [63:0] C_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] C_MIX_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] C_MIX_B  = 64'h94D049BB133111EB;
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef struct packed {
        req_t                req;
        logic [PROBE_W-1:0]  h1;
        logic [PROBE_W-1:0]  h2;
        logic [WIDX_W-1:0]   word_index;
        logic [WORD_W-1:0]   word_data;
    } job_t;

    typedef struct packed {
        logic [COUNT_W-1:0] probe_count;
        logic [PROBE_W-1:0] index_mask;
    } probe_cfg_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MIX30,
        F_MUL1_LO,
        F_MUL1_HI,
        F_MUL1_X,
        F_MIX27,
        F_MUL2_LO,
        F_MUL2_HI,
        F_MUL2_X,
        F_FINAL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_INS_RD,
        B_INS_WR,
        B_QRY,
        B_WORD_WR,
        B_WORD_RD,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/bfdh_ram.sv
`default_nettype none

module bfdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      clk,
    input  wire logic                                      en,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/bfdh_queue.sv
`default_nettype none

module bfdh_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire bfdh_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output bfdh_pkg::job_t     pop_job
);

    localparam int DEPTH = bfdh_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bfdh_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push_fire, pop_fire;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bfdh_front.sv
`default_nettype none

// Takes requests and works out both hashes on one shared 32x32 multiplier.
// Each 64-bit product (low half) is built from three partial products.
module bfdh_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          enable,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bfdh_pkg::req_t                in_req,
    input  wire logic [bfdh_pkg::FP_W-1:0]     in_fp,
    input  wire logic [bfdh_pkg::WIDX_W-1:0]   in_widx,
    input  wire logic [bfdh_pkg::WORD_W-1:0]   in_wdata,
    input  wire logic [63:0]                   hash_seed,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output bfdh_pkg::job_t                     push_job
);

    localparam int PW = bfdh_pkg::PROBE_W;

    bfdh_pkg::front_state_t state_reg, state_next;
    logic                   round_reg, round_next;
    logic [63:0]            z_reg, z_next;
    logic [63:0]            acc_reg, acc_next;
    logic [PW-1:0]          h1_reg, h1_next;
    logic [PW-1:0]          h2_reg, h2_next;
    bfdh_pkg::req_t         req_reg, req_next;
    logic [bfdh_pkg::WIDX_W-1:0] widx_reg, widx_next;
    logic [bfdh_pkg::WORD_W-1:0] wdata_reg, wdata_next;

    logic [63:0] mix_k;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] upper_sum;
    logic [63:0] fin;
    logic        second_mul, hi_step, cross_step;

    assign second_mul = (state_reg == bfdh_pkg::F_MUL2_LO) || (state_reg == bfdh_pkg::F_MUL2_HI)
                        || (state_reg == bfdh_pkg::F_MUL2_X);
    assign hi_step    = (state_reg == bfdh_pkg::F_MUL1_HI) || (state_reg == bfdh_pkg::F_MUL2_HI);
    assign cross_step = (state_reg == bfdh_pkg::F_MUL1_X) || (state_reg == bfdh_pkg::F_MUL2_X);

    assign mix_k     = second_mul ? bfdh_pkg::C_MIX_B : bfdh_pkg::C_MIX_A;
    assign mul_a     = hi_step ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = cross_step ? mix_k[63:32] : mix_k[31:0];
    assign prod      = 64'(mul_a) * 64'(mul_b);
    assign upper_sum = acc_reg[63:32] + prod[31:0];
    assign fin       = z_reg ^ (z_reg >> bfdh_pkg::SHIFT_C);

    assign push_job.req        = req_reg;
    assign push_job.h1         = h1_reg;
    assign push_job.h2         = h2_reg;
    assign push_job.word_index = widx_reg;
    assign push_job.word_data  = wdata_reg;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        req_next   = req_reg;
        widx_next  = widx_reg;
        wdata_next = wdata_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            bfdh_pkg::F_IDLE:
            begin
                in_ready = enable;
                if (in_valid && enable)
                begin
                    req_next   = in_req;
                    widx_next  = in_widx;
                    wdata_next = in_wdata;
                    z_next     = in_fp + bfdh_pkg::C_GOLDEN;
                    round_next = 1'b0;
                    if (in_req == bfdh_pkg::REQ_INSERT || in_req == bfdh_pkg::REQ_QUERY)
                    begin
                        state_next = bfdh_pkg::F_MIX30;
                    end
                    else
                    begin
                        state_next = bfdh_pkg::F_PUSH;
                    end
                end
            end
            bfdh_pkg::F_MIX30:
            begin
                z_next     = z_reg ^ (z_reg >> bfdh_pkg::SHIFT_A);
                state_next = bfdh_pkg::F_MUL1_LO;
            end
            bfdh_pkg::F_MUL1_LO:
            begin
                acc_next   = prod;
                state_next = bfdh_pkg::F_MUL1_HI;
            end
            bfdh_pkg::F_MUL1_HI:
            begin
                acc_next   = {upper_sum, acc_reg[31:0]};
                state_next = bfdh_pkg::F_MUL1_X;
            end
            bfdh_pkg::F_MUL1_X:
            begin
                z_next     = {upper_sum, acc_reg[31:0]};
                state_next = bfdh_pkg::F_MIX27;
            end
            bfdh_pkg::F_MIX27:
            begin
                z_next     = z_reg ^ (z_reg >> bfdh_pkg::SHIFT_B);
                state_next = bfdh_pkg::F_MUL2_LO;
            end
            bfdh_pkg::F_MUL2_LO:
            begin
                acc_next   = prod;
                state_next = bfdh_pkg::F_MUL2_HI;
            end
            bfdh_pkg::F_MUL2_HI:
            begin
                acc_next   = {upper_sum, acc_reg[31:0]};
                state_next = bfdh_pkg::F_MUL2_X;
            end
            bfdh_pkg::F_MUL2_X:
            begin
                z_next     = {upper_sum, acc_reg[31:0]};
                state_next = bfdh_pkg::F_FINAL;
            end
            bfdh_pkg::F_FINAL:
            begin
                if (!round_reg)
                begin
                    // The second hash starts from h1 xor seed.
                    h1_next    = fin[PW-1:0];
                    z_next     = (fin ^ hash_seed) + bfdh_pkg::C_GOLDEN;
                    round_next = 1'b1;
                    state_next = bfdh_pkg::F_MIX30;
                end
                else
                begin
                    h2_next    = fin[PW-1:0];
                    state_next = bfdh_pkg::F_PUSH;
                end
            end
            bfdh_pkg::F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = bfdh_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = bfdh_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfdh_pkg::F_IDLE;
            round_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        req_reg   <= req_next;
        widx_reg  <= widx_next;
        wdata_reg <= wdata_next;
    end

endmodule

`default_nettype wire

### hw/rtl/bfdh_back.sv
`default_nettype none

// Runs queued jobs against the single-port bit store and holds the result.
module bfdh_back #(
    parameter int MAX_FILTER_BITS = bfdh_pkg::DEF_MAX_FILTER_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    output logic                               clearing,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire bfdh_pkg::job_t                pop_job,
    input  wire bfdh_pkg::probe_cfg_t          probe_cfg,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               maybe_present,
    output logic [bfdh_pkg::WORD_W-1:0]        word_out
);

    localparam int STORE_WORDS = MAX_FILTER_BITS / 64;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int PW          = bfdh_pkg::PROBE_W;
    localparam int WW          = bfdh_pkg::WORD_W;
    localparam int BW          = bfdh_pkg::BIT_SEL_W;

    bfdh_pkg::back_state_t   state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    bfdh_pkg::job_t          job_reg, job_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [bfdh_pkg::COUNT_W-1:0] left_reg, left_next;
    logic                    chk_pend_reg, chk_pend_next;
    logic [BW-1:0]           chk_bit_reg, chk_bit_next;
    logic                    present_reg, present_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_present_reg, out_present_next;
    logic [WW-1:0]           out_word_reg, out_word_next;

    logic                    ram_en, ram_we;
    logic [ADDR_W-1:0]       ram_addr;
    logic [WW-1:0]           ram_wdata, ram_rdata;

    logic [PW-1:0]           masked;
    logic [ADDR_W-1:0]       probe_addr;
    logic [BW-1:0]           probe_bit;
    logic                    widx_ok;

    bfdh_ram #(
        .WIDTH (WW),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign masked     = pos_reg & probe_cfg.index_mask;
    assign probe_addr = ADDR_W'(masked >> BW);
    assign probe_bit  = masked[BW-1:0];
    assign widx_ok    = (32'(job_reg.word_index) < 32'(STORE_WORDS));

    assign clearing      = (state_reg == bfdh_pkg::B_CLEAR);
    assign out_valid     = out_valid_reg;
    assign maybe_present = out_present_reg;
    assign word_out      = out_word_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        job_next         = job_reg;
        pos_next         = pos_reg;
        left_next        = left_reg;
        chk_pend_next    = chk_pend_reg;
        chk_bit_next     = chk_bit_reg;
        present_next     = present_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_present_next = out_present_reg;
        out_word_next    = out_word_reg;
        pop_ready        = 1'b0;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = probe_addr;
        ram_wdata        = '0;
        unique case (state_reg)
            bfdh_pkg::B_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_WORDS - 1))
                begin
                    state_next = bfdh_pkg::B_IDLE;
                end
            end
            bfdh_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    job_next      = pop_job;
                    pos_next      = pop_job.h1;
                    left_next     = probe_cfg.probe_count;
                    present_next  = 1'b1;
                    chk_pend_next = 1'b0;
                    unique case (pop_job.req)
                        bfdh_pkg::REQ_INSERT:
                        begin
                            state_next = (probe_cfg.probe_count == '0) ? bfdh_pkg::B_DONE
                                                                       : bfdh_pkg::B_INS_RD;
                        end
                        bfdh_pkg::REQ_QUERY:
                        begin
                            state_next = (probe_cfg.probe_count == '0) ? bfdh_pkg::B_DONE
                                                                       : bfdh_pkg::B_QRY;
                        end
                        bfdh_pkg::REQ_WRITE:
                        begin
                            state_next = bfdh_pkg::B_WORD_WR;
                        end
                        bfdh_pkg::REQ_READ:
                        begin
                            state_next = bfdh_pkg::B_WORD_RD;
                        end
                        default:
                        begin
                            state_next = bfdh_pkg::B_DONE;
                        end
                    endcase
                end
            end
            bfdh_pkg::B_INS_RD:
            begin
                ram_en       = 1'b1;
                chk_bit_next = probe_bit;
                state_next   = bfdh_pkg::B_INS_WR;
            end
            bfdh_pkg::B_INS_WR:
            begin
                // Read-modify-write; the next probe's read sees this write.
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (WW'(1) << chk_bit_reg);
                pos_next  = pos_reg + job_reg.h2;
                left_next = left_reg - 1'b1;
                state_next = (left_reg == bfdh_pkg::COUNT_W'(1)) ? bfdh_pkg::B_DONE
                                                                 : bfdh_pkg::B_INS_RD;
            end
            bfdh_pkg::B_QRY:
            begin
                // Reads are issued back to back; each read's data is checked in the next cycle.
                if (left_reg != '0)
                begin
                    ram_en        = 1'b1;
                    chk_pend_next = 1'b1;
                    chk_bit_next  = probe_bit;
                    pos_next      = pos_reg + job_reg.h2;
                    left_next     = left_reg - 1'b1;
                end
                else
                begin
                    chk_pend_next = 1'b0;
                    state_next    = bfdh_pkg::B_DONE;
                end
                if (chk_pend_reg && !ram_rdata[chk_bit_reg])
                begin
                    present_next = 1'b0;
                end
            end
            bfdh_pkg::B_WORD_WR:
            begin
                ram_en     = widx_ok;
                ram_we     = widx_ok;
                ram_addr   = ADDR_W'(job_reg.word_index);
                ram_wdata  = job_reg.word_data;
                state_next = bfdh_pkg::B_DONE;
            end
            bfdh_pkg::B_WORD_RD:
            begin
                ram_en     = widx_ok;
                ram_addr   = ADDR_W'(job_reg.word_index);
                state_next = bfdh_pkg::B_DONE;
            end
            bfdh_pkg::B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_present_next = (job_reg.req == bfdh_pkg::REQ_QUERY) && present_reg;
                    out_word_next    = ((job_reg.req == bfdh_pkg::REQ_READ) && widx_ok)
                                       ? ram_rdata : '0;
                    state_next       = bfdh_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = bfdh_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfdh_pkg::B_CLEAR;
            clr_reg       <= '0;
            chk_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_pend_reg  <= chk_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg         <= job_next;
        pos_reg         <= pos_next;
        left_reg        <= left_next;
        chk_bit_reg     <= chk_bit_next;
        present_reg     <= present_next;
        out_present_reg <= out_present_next;
        out_word_reg    <= out_word_next;
    end

endmodule

`default_nettype wire

### hw/rtl/bloom_filter_double_hash_top.sv
`default_nettype none

// Bloom filter with double hashing over 64-bit fingerprints, one result per
// request. After reset the bit store is cleared one word per cycle; no request
// is taken while it clears, while configuration writes are. The front computes
// both hashes on one shared 32x32 multiplier; word writes and reads skip the
// hashing. A two-entry queue lets the front hash the next fingerprint while the
// back probes the single-port store, an insert with a read-modify-write per
// probe. MAX_FILTER_BITS must be a power of two.
module bloom_filter_double_hash_top #(
    parameter int MAX_FILTER_BITS = bfdh_pkg::DEF_MAX_FILTER_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // fingerprint[63:0], word_index[73:64], word_data[137:74], zero pad
    input  wire logic [bfdh_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // req_type[1:0]
    input  wire logic [bfdh_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // maybe_present[0], word_out[64:1], zero pad
    output logic [bfdh_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [bfdh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CAP_LOG2 = $clog2(MAX_FILTER_BITS);
    localparam int PW       = bfdh_pkg::PROBE_W;
    localparam int MASK_W   = PW + 1;
    localparam int LW       = bfdh_pkg::LOG2_W;
    localparam int CW       = bfdh_pkg::COUNT_W;

    logic [CW-1:0]   hash_count_reg;
    logic [63:0]     hash_seed_reg;
    logic [LW-1:0]   size_log2_reg;

    logic [LW-1:0]   eff_log2;
    logic [MASK_W-1:0] mask_full;
    bfdh_pkg::probe_cfg_t probe_cfg;

    logic            clearing;
    logic            push_valid, push_ready;
    bfdh_pkg::job_t  push_job;
    logic            pop_valid, pop_ready;
    bfdh_pkg::job_t  pop_job;
    logic            maybe_present;
    logic [bfdh_pkg::WORD_W-1:0] word_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg <= bfdh_pkg::HASH_COUNT_RESET;
            hash_seed_reg  <= '0;
            size_log2_reg  <= bfdh_pkg::SIZE_LOG2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfdh_pkg::CFG_HASH_COUNT: hash_count_reg <= cfg_data[CW-1:0];
                bfdh_pkg::CFG_HASH_SEED:  hash_seed_reg  <= cfg_data;
                bfdh_pkg::CFG_SIZE_LOG2:  size_log2_reg  <= cfg_data[LW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (size_log2_reg < LW'(bfdh_pkg::MIN_SIZE_LOG2))
        begin
            eff_log2 = LW'(bfdh_pkg::MIN_SIZE_LOG2);
        end
        else if (size_log2_reg > LW'(CAP_LOG2))
        begin
            eff_log2 = LW'(CAP_LOG2);
        end
        else
        begin
            eff_log2 = size_log2_reg;
        end
    end

    assign mask_full = (MASK_W'(1) << eff_log2) - MASK_W'(1);
    assign probe_cfg.index_mask  = mask_full[PW-1:0];
    assign probe_cfg.probe_count = (hash_count_reg > CW'(bfdh_pkg::MAX_PROBES))
                                   ? CW'(bfdh_pkg::MAX_PROBES) : hash_count_reg;

    bfdh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!clearing),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (bfdh_pkg::req_t'(s_axis_tuser)),
        .in_fp      (s_axis_tdata[63:0]),
        .in_widx    (s_axis_tdata[73:64]),
        .in_wdata   (s_axis_tdata[137:74]),
        .hash_seed  (hash_seed_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    bfdh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    bfdh_back #(
        .MAX_FILTER_BITS (MAX_FILTER_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clearing      (clearing),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_job       (pop_job),
        .probe_cfg     (probe_cfg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .maybe_present (maybe_present),
        .word_out      (word_out)
    );

    assign m_axis_tdata = {bfdh_pkg::M_PAD_W'(0), word_out, maybe_present};

endmodule

`default_nettype wire

### hw/rtl/bfdh_checker.sv
`default_nettype none

`include "bloom_filter_double_hash_top_macros.svh"

module bfdh_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [bfdh_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    // Requests accepted whose result has not yet been taken.
    logic [3:0] pending_reg, pending_next;
    logic       in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        case ({in_fire, out_fire})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `BFDH_ASSERT_NEXT(out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `BFDH_ASSERT_NOW(out_has_request, m_axis_tvalid, pending_reg != 4'd0)
    `BFDH_ASSERT_NOW(out_one_kind, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[64:1] == 64'd0)
    `BFDH_ASSERT_NOW(pending_bounded, s_axis_tvalid || m_axis_tvalid || !s_axis_tvalid, pending_reg <= 4'd5)

endmodule

bind bloom_filter_double_hash_top bfdh_checker u_bfdh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfdh_pkg::*;

    localparam int STORE_DEPTH  = DEF_MAX_FILTER_BITS / 64;
    localparam int FILTER_LOG2  = $clog2(DEF_MAX_FILTER_BITS);
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 800;
    localparam int PHASE_ITEMS  = 154;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        req_t              req;
        logic [FP_W-1:0]   fp;
        logic [WIDX_W-1:0] widx;
        logic [WORD_W-1:0] data;
    } request_t;

    typedef struct {
        logic              present;
        logic [WORD_W-1:0] word;
    } answer_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TOGGLE
    } ready_mode_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bloom_filter_double_hash_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the filter and its settings.
    logic [WORD_W-1:0]  store_model [0:STORE_DEPTH-1];
    logic [COUNT_W-1:0] probe_count_cfg = HASH_COUNT_RESET;
    logic [63:0]        seed_cfg = '0;
    logic [LOG2_W-1:0]  size_log2_cfg = SIZE_LOG2_RESET;

    request_t requests_todo [$];
    answer_t  answers_due [$];
    logic [FP_W-1:0] inserted_fps [$];
    int mismatches = 0;
    bit hold_go = 1'b0;

    initial
    begin
        for (int w = 0; w < STORE_DEPTH; w++)
            store_model[w] = '0;
    end

    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] z;
        z = v + C_GOLDEN;
        z = (z ^ (z >> SHIFT_A)) * C_MIX_A;
        z = (z ^ (z >> SHIFT_B)) * C_MIX_B;
        return z ^ (z >> SHIFT_C);
    endfunction

    // Applies one request to the shadow filter and returns the answer it must give.
    function automatic answer_t bloom_result(input request_t r);
        answer_t     a;
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] mask;
        logic [63:0] pos;
        logic [63:0] k;
        int          lg;
        int          n;
        logic        hit;
        a.present = 1'b0;
        a.word = '0;
        case (r.req) inside
            REQ_INSERT, REQ_QUERY:
            begin
                h1 = mix64(r.fp);
                h2 = mix64(h1 ^ seed_cfg);
                lg = size_log2_cfg;
                if (lg < MIN_SIZE_LOG2)
                    lg = MIN_SIZE_LOG2;
                if (lg > FILTER_LOG2)
                    lg = FILTER_LOG2;
                mask = (64'd1 << lg) - 64'd1;
                n = (probe_count_cfg > MAX_PROBES) ? MAX_PROBES : probe_count_cfg;
                hit = 1'b1;
                k = '0;
                for (int i = 0; i < n; i++)
                begin
                    pos = (h1 + k * h2) & mask;
                    if (r.req == REQ_INSERT)
                        store_model[pos >> 6][pos[5:0]] = 1'b1;
                    else if (!store_model[pos >> 6][pos[5:0]])
                        hit = 1'b0;
                    k = k + 64'd1;
                end
                if (r.req == REQ_QUERY)
                    a.present = hit;
            end
            REQ_WRITE:
            begin
                if (r.widx < STORE_DEPTH)
                    store_model[r.widx] = r.data;
            end
            default:
            begin
                if (r.widx < STORE_DEPTH)
                    a.word = store_model[r.widx];
            end
        endcase
        return a;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("bloom_filter_double_hash_top: mismatch");
        $finish;
    end

    // Sender: bursts of transfers separated by random gaps.
    request_t cur_req;
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                answers_due.push_back(bloom_result(cur_req));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (requests_todo.size() != 0)
                begin
                    cur_req = requests_todo.pop_front();
                    s_axis_tdata <= {{S_PAD_W{1'b0}}, cur_req.data, cur_req.widx, cur_req.fp};
                    s_axis_tuser <= cur_req.req;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                                  : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
    ready_mode_t ready_mode = RDY_ALWAYS;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_taken = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            else
                mode_left--;
            case (ready_mode)
                RDY_ALWAYS: m_axis_tready <= 1'b1;
                RDY_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:    m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // Result checker.
    answer_t got;
    answer_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.present = m_axis_tdata[0];
            got.word = m_axis_tdata[WORD_W:1];
            if (answers_due.size() == 0)
            begin
                $error("result transfer with nothing outstanding: tdata %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (got.present !== want.present)
                begin
                    $error("maybe_present: expected %0d, actual %0d", want.present, got.present);
                    mismatches++;
                end
                if (got.word !== want.word)
                begin
                    $error("word_out: expected %h, actual %h", want.word, got.word);
                    mismatches++;
                end
                if (m_axis_tdata[M_TDATA_W-1:WORD_W+1] !== '0)
                begin
                    $error("pad: expected 0, actual %h", m_axis_tdata[M_TDATA_W-1:WORD_W+1]);
                    mismatches++;
                end
            end
        end
    end

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_HASH_COUNT: probe_count_cfg = value[COUNT_W-1:0];
            CFG_HASH_SEED:  seed_cfg = value;
            CFG_SIZE_LOG2:  size_log2_cfg = value[LOG2_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_filter(input int count, input logic [63:0] seed, input int lg);
        set_reg(CFG_HASH_COUNT, 64'(count));
        set_reg(CFG_HASH_SEED, seed);
        set_reg(CFG_SIZE_LOG2, 64'(lg));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (requests_todo.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_req(input req_t kind, input logic [63:0] fp,
                            input logic [WIDX_W-1:0] widx, input logic [63:0] data);
        request_t r;
        r.req = kind;
        r.fp = fp;
        r.widx = widx;
        r.data = data;
        requests_todo.push_back(r);
    endtask

    // Mostly inserts and queries of fingerprints already inserted, so that hits are common.
    task automatic push_random_req();
        int          pick;
        logic [63:0] fp;
        logic [63:0] data;
        logic [WIDX_W-1:0] widx;
        pick = $urandom_range(0, 99);
        fp = rand64();
        data = rand64();
        widx = ($urandom_range(0, 1) == 0) ? WIDX_W'($urandom_range(0, 3))
                                           : WIDX_W'($urandom_range(0, 1023));
        if (pick < 30)
        begin
            inserted_fps.push_back(fp);
            if (inserted_fps.size() > 64)
                void'(inserted_fps.pop_front());
            push_req(REQ_INSERT, fp, widx, data);
        end
        else if (pick < 65)
        begin
            if (inserted_fps.size() != 0 && $urandom_range(0, 9) < 6)
                fp = inserted_fps[$urandom_range(0, inserted_fps.size() - 1)];
            push_req(REQ_QUERY, fp, widx, data);
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 3))
                0: data = '0;
                1: data = ALL_ONES;
                default: ;
            endcase
            push_req(REQ_WRITE, fp, widx, data);
        end
        else
            push_req(REQ_READ, fp, widx, data);
    endtask

    int          phase_count [8] = '{1, 16, 0, 31, 20, 7, 9, 3};
    int          phase_log2 [8]  = '{6, 16, 10, 3, 31, 12, 8, 7};
    logic [63:0] probe_fp;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_filter(HASH_COUNT_RESET, 64'd0, SIZE_LOG2_RESET);

        // Directed: empty filter, extreme fingerprints, store words at both ends.
        push_req(REQ_QUERY, 64'd0, '0, '0);
        push_req(REQ_INSERT, 64'd0, '0, '0);
        push_req(REQ_QUERY, 64'd0, '0, '0);
        push_req(REQ_INSERT, ALL_ONES, '1, ALL_ONES);
        push_req(REQ_QUERY, ALL_ONES, '1, ALL_ONES);
        push_req(REQ_READ, 64'd0, 10'd0, '0);
        push_req(REQ_WRITE, 64'd0, 10'd0, ALL_ONES);
        push_req(REQ_WRITE, ALL_ONES, 10'd1023, 64'h5555_5555_5555_5555);
        push_req(REQ_READ, 64'd0, 10'd0, '0);
        push_req(REQ_READ, 64'd0, 10'd1023, '0);
        push_req(REQ_WRITE, 64'd0, 10'd1023, '0);
        push_req(REQ_READ, ALL_ONES, 10'd1023, ALL_ONES);
        wait_idle();

        // No probes at all, and a size below the minimum.
        set_filter(0, ALL_ONES, 0);
        probe_fp = rand64();
        push_req(REQ_QUERY, probe_fp, '0, '0);
        push_req(REQ_INSERT, probe_fp, '0, '0);
        push_req(REQ_READ, probe_fp, 10'd0, '0);
        wait_idle();

        // Count saturates at sixteen and the size is clipped to the store.
        set_filter(31, rand64(), 31);
        probe_fp = rand64();
        push_req(REQ_INSERT, probe_fp, '0, '0);
        push_req(REQ_QUERY, probe_fp, '0, '0);
        push_req(REQ_QUERY, ~probe_fp, '0, '0);
        wait_idle();

        set_filter(MAX_PROBES, 64'd0, MIN_SIZE_LOG2);
        probe_fp = rand64();
        push_req(REQ_WRITE, probe_fp, 10'd0, '0);
        push_req(REQ_INSERT, probe_fp, '0, '0);
        push_req(REQ_QUERY, probe_fp, '0, '0);
        push_req(REQ_READ, probe_fp, 10'd0, '0);
        push_req(REQ_READ, probe_fp, 10'd1, '0);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            set_filter(phase_count[p], (p == 1) ? ALL_ONES : (p == 0) ? 64'd0 : rand64(),
                       phase_log2[p]);
            inserted_fps.delete();
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_req();
            // Let the output back up while the sender keeps offering requests.
            if (p == 1)
                hold_go = 1'b1;
            wait_idle();
        end

        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("bloom_filter_double_hash_top: match");
        else
            $display("bloom_filter_double_hash_top: mismatch");
        $finish;
    end

endmodule
